### hw/rtl/kdpr_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard and display port package
// Shared types and constants for the keyboard and display port registers.
// ----------------------------------------------------------------------------
`default_nettype none

package kdpr_pkg;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_BUS_READ   = 2'd0,
    FUNC_BUS_WRITE  = 2'd1,
    FUNC_KEY_OFFER  = 2'd2,
    FUNC_DISP_POLL  = 2'd3
  } func_t;

  // Register selects within the four-byte window.
  typedef enum logic [1:0] {
    REG_KEY_CLEAR   = 2'd0,
    REG_KEY_PEEK    = 2'd1,
    REG_DISPLAY     = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_sel_t;

  localparam logic [15:0] REG_ADDR_MASK = 16'hFFFC;
  localparam logic [7:0]  NEW_FLAG      = 8'h80;
  localparam logic [7:0]  LOW7_MASK     = 8'h7F;
  localparam logic [15:0] BASE_RESET    = 16'hD010;

  // One result word.
  typedef struct packed {
    logic [7:0] read_data;
    logic       drive_bus;
    logic       key_accepted;
    logic       char_valid;
    logic [6:0] char_out;
  } result_t;

endpackage : kdpr_pkg

`default_nettype wire

### hw/rtl/keyboard_display_port_registers.sv
// ----------------------------------------------------------------------------
// Keyboard and display port registers
// Three byte-wide registers in a four-byte window on a processor bus, with key and display latches.
// ----------------------------------------------------------------------------
// Usage notes.
// Input words arrive on in_valid / in_stall with the fields func, bus_address,
// write_data and key_code. A word is taken at a rising edge where in_valid is
// high and in_stall is low. Each input word yields exactly one result word on
// out_valid / out_stall, carrying read_data, drive_bus, key_accepted,
// char_valid and char_out.
// The datapath is an input register followed by a result register, with the
// decode and latch update done in one short combinational pass between them.
// A result is therefore registered as its word leaves the input register, and a
// new word can be accepted every cycle, so the sustained rate is one word per
// clock while the receiver keeps out_stall low.
// The key and display latches are updated as a word moves from the input
// register into the result register, so each word sees the effect of all
// earlier words in order.
// When the receiver stalls, the result register holds its word; the input
// register may still take one more word, after which in_stall rises until the
// result register frees up.
// A synchronous reset empties both stages, clears both latches and loads the
// base address with its reset value. The base address is written through
// cfg_write_enable / cfg_write_data and should only be changed while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_display_port_registers
  import kdpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration
  input  wire logic        cfg_write_enable,
  input  wire logic [15:0] cfg_write_data,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  key_code,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             drive_bus,
  output logic             key_accepted,
  output logic             char_valid,
  output logic [6:0]       char_out
);

  // Configuration register.
  logic [15:0] base_address;

  // Input register.
  logic        in_reg_valid;
  func_t       in_reg_func;
  logic [15:0] in_reg_address;
  logic [7:0]  in_reg_write_data;
  logic [7:0]  in_reg_key_code;

  // Latches.
  logic [7:0]  key_latch;
  logic [7:0]  key_latch_next;
  logic [7:0]  display_latch;
  logic [7:0]  display_latch_next;

  // Result register.
  result_t     result;
  result_t     result_next;

  logic        advance;
  logic        in_accept;
  logic        hit;
  reg_sel_t    reg_sel;

  // The result register can take a new word whenever it is empty or being
  // drained this cycle.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  assign hit     = (in_reg_address & REG_ADDR_MASK) == (base_address & REG_ADDR_MASK);
  assign reg_sel = reg_sel_t'(in_reg_address[1:0]);

  always_comb begin
    key_latch_next     = key_latch;
    display_latch_next = display_latch;
    result_next        = '0;
    case (in_reg_func)
      FUNC_BUS_READ: begin
        if (hit) begin
          case (reg_sel)
            REG_KEY_CLEAR: begin
              result_next.read_data = key_latch | NEW_FLAG;
              result_next.drive_bus = 1'b1;
              key_latch_next        = key_latch & LOW7_MASK;
            end
            REG_KEY_PEEK: begin
              result_next.read_data = key_latch;
              result_next.drive_bus = 1'b1;
            end
            REG_DISPLAY: begin
              result_next.read_data = display_latch;
              result_next.drive_bus = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      FUNC_BUS_WRITE: begin
        if (hit && reg_sel == REG_DISPLAY) begin
          display_latch_next = in_reg_write_data | NEW_FLAG;
        end
      end
      FUNC_KEY_OFFER: begin
        if (!key_latch[7]) begin
          key_latch_next           = in_reg_key_code | NEW_FLAG;
          result_next.key_accepted = 1'b1;
        end
      end
      default: begin
        // Display poll.
        if (display_latch[7]) begin
          result_next.char_valid = 1'b1;
          result_next.char_out   = display_latch[6:0];
          display_latch_next     = display_latch & LOW7_MASK;
        end
      end
    endcase
  end

  // Control state and latches.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= BASE_RESET;
      in_reg_valid  <= 1'b0;
      out_valid     <= 1'b0;
      key_latch     <= '0;
      display_latch <= '0;
    end else begin
      if (cfg_write_enable) begin
        base_address <= cfg_write_data;
      end
      if (advance) begin
        out_valid <= in_reg_valid;
        if (in_reg_valid) begin
          key_latch     <= key_latch_next;
          display_latch <= display_latch_next;
        end
      end
      if (in_accept) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_func       <= func_t'(func);
      in_reg_address    <= bus_address;
      in_reg_write_data <= write_data;
      in_reg_key_code   <= key_code;
    end
    if (advance && in_reg_valid) begin
      result <= result_next;
    end
  end

  assign read_data    = result.read_data;
  assign drive_bus    = result.drive_bus;
  assign key_accepted = result.key_accepted;
  assign char_valid   = result.char_valid;
  assign char_out     = result.char_out;

endmodule : keyboard_display_port_registers

`default_nettype wire

### hw/rtl/kdpr_checker.sv
// ----------------------------------------------------------------------------
// Keyboard and display port checker
// Port-level checks on the result channel of the keyboard and display port.
// ----------------------------------------------------------------------------
`default_nettype none

module kdpr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] read_data,
  input wire logic       drive_bus,
  input wire logic       key_accepted,
  input wire logic       char_valid,
  input wire logic [6:0] char_out
);

  // Reset empties the result stage.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(char_out))
    else $error("stalled result word changed");

  // One word reports at most one kind of outcome.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({drive_bus, key_accepted, char_valid}))
    else $error("result word reports more than one outcome");

  // Undriven read data is zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_bus |-> read_data == 8'h00)
    else $error("read data set without a bus answer");

  // No character without char_valid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> char_out == 7'h00)
    else $error("character set without char_valid");

endmodule : kdpr_checker

bind keyboard_display_port_registers kdpr_checker u_kdpr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .read_data    (read_data),
  .drive_bus    (drive_bus),
  .key_accepted (key_accepted),
  .char_valid   (char_valid),
  .char_out     (char_out)
);

`default_nettype wire

### sim/keyboard_display_port_registers_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard and display port registers testbench
// Drives bus accesses, key offers and display polls into the port, predicts
// every result word from a behavioural copy of the two latches and the base
// address, and compares each result field by field.
// ----------------------------------------------------------------------------

module keyboard_display_port_registers_tb;
  import kdpr_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 144;
  localparam int HEAVY_PCT   = 59;
  localparam int LIGHT_PCT   = 9;
  // Roughly 1200 words in all; the limit is far above what even the worst mode
  // needs, so that only a hang can reach it.
  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One input word as the sender presents it.
  typedef struct {
    func_t       op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  key;
  } port_word_t;

  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [15:0] cfg_write_data   = '0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  func             = '0;
  logic [15:0] bus_address      = '0;
  logic [7:0]  write_data       = '0;
  logic [7:0]  key_code         = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  read_data;
  logic        drive_bus;
  logic        key_accepted;
  logic        char_valid;
  logic [6:0]  char_out;

  keyboard_display_port_registers u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .bus_address      (bus_address),
    .write_data       (write_data),
    .key_code         (key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .drive_bus        (drive_bus),
    .key_accepted     (key_accepted),
    .char_valid       (char_valid),
    .char_out         (char_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Words waiting to be presented, and the responses that accepted words
  // are owed, oldest first.
  port_word_t  pending_words[$];
  result_t     expected_responses[$];

  // Handshake bookkeeping. The driver counts words it has presented, the
  // monitor counts words the block has taken; while the two differ the
  // current word is still on the port and must be held.
  int          words_offered = 0;
  int          words_taken   = 0;
  int          cycle_count   = 0;
  int          mismatches    = 0;
  int          results_checked = 0;
  int          reads_answered  = 0;
  int          keys_latched    = 0;
  int          chars_drained   = 0;
  idle_mode_t  idle_mode     = IDLE_NONE;

  // Base address that the stimulus aims at, and the predictor's own copy of
  // the register and both latches. The predictor copy of the base is only
  // updated when the block itself sees the write.
  logic [15:0] stim_base        = BASE_RESET;
  logic [15:0] model_base       = BASE_RESET;
  logic [7:0]  model_key_latch  = '0;
  logic [7:0]  model_display_latch = '0;

  // Works out the response to one word and advances the latch copies. Every
  // field that the function does not produce stays at zero.
  function automatic result_t predict_port_response(func_t op, logic [15:0] addr,
                                                    logic [7:0] wdata, logic [7:0] key);
    result_t  resp;
    logic     hit;
    reg_sel_t sel;
    resp = '0;
    hit  = (addr & REG_ADDR_MASK) == (model_base & REG_ADDR_MASK);
    sel  = reg_sel_t'(addr[1:0]);
    case (op)
      FUNC_BUS_READ: begin
        if (hit) begin
          case (sel)
            REG_KEY_CLEAR: begin
              // Reading the key register always shows the flag set, then
              // clears it so the host may offer the next key.
              resp.read_data  = model_key_latch | NEW_FLAG;
              resp.drive_bus  = 1'b1;
              model_key_latch = model_key_latch & LOW7_MASK;
            end
            REG_KEY_PEEK: begin
              resp.read_data = model_key_latch;
              resp.drive_bus = 1'b1;
            end
            REG_DISPLAY: begin
              resp.read_data = model_display_latch;
              resp.drive_bus = 1'b1;
            end
            default: begin
              // The fourth register is not decoded, so the bus is left alone.
            end
          endcase
        end
      end
      FUNC_BUS_WRITE: begin
        if (hit && sel == REG_DISPLAY) begin
          model_display_latch = wdata | NEW_FLAG;
        end
      end
      FUNC_KEY_OFFER: begin
        // A key is only taken once the processor has consumed the last one.
        if ((model_key_latch & NEW_FLAG) == '0) begin
          model_key_latch   = key | NEW_FLAG;
          resp.key_accepted = 1'b1;
        end
      end
      default: begin
        if ((model_display_latch & NEW_FLAG) != '0) begin
          resp.char_valid     = 1'b1;
          resp.char_out       = model_display_latch[6:0];
          model_display_latch = model_display_latch & LOW7_MASK;
        end
      end
    endcase
    return resp;
  endfunction

  function automatic logic [15:0] reg_address(reg_sel_t sel);
    return {stim_base[15:2], sel};
  endfunction

  // Mostly addresses inside the current window, some one bit away from it,
  // and some anywhere in the address space.
  function automatic logic [15:0] random_address();
    int          pick;
    logic [13:0] near;
    pick = $urandom_range(99);
    near = stim_base[15:2] ^ (14'd1 << $urandom_range(13));
    if (pick < 75) begin
      return {stim_base[15:2], 2'($urandom_range(3))};
    end else if (pick < 87) begin
      return {near, 2'($urandom_range(3))};
    end else begin
      return 16'($urandom);
    end
  endfunction

  task automatic queue_word(func_t op, logic [15:0] addr, logic [7:0] wdata,
                            logic [7:0] key);
    port_word_t w;
    w.op    = op;
    w.addr  = addr;
    w.wdata = wdata;
    w.key   = key;
    pending_words.push_back(w);
  endtask

  // Random traffic. Most of it follows the two protocols the port exists
  // for: the host offers a key and the processor peeks and then reads it,
  // or the processor writes a character, reads it back and the host drains
  // it. The rest is unstructured noise over every function.
  task automatic queue_random_words(int count);
    int made;
    int kind;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        queue_word(FUNC_KEY_OFFER, random_address(), 8'($urandom), 8'($urandom));
        queue_word(FUNC_BUS_READ, reg_address(REG_KEY_PEEK), 8'($urandom), 8'($urandom));
        queue_word(FUNC_BUS_READ, reg_address(REG_KEY_CLEAR), 8'($urandom),
                   8'($urandom));
        made += 3;
      end else if (kind < 60) begin
        queue_word(FUNC_BUS_WRITE, reg_address(REG_DISPLAY), 8'($urandom), 8'($urandom));
        queue_word(FUNC_BUS_READ, reg_address(REG_DISPLAY), 8'($urandom), 8'($urandom));
        queue_word(FUNC_DISP_POLL, random_address(), 8'($urandom), 8'($urandom));
        made += 3;
      end else begin
        queue_word(func_t'($urandom_range(3)), random_address(), 8'($urandom),
                   8'($urandom));
        made++;
      end
    end
  endtask

  // Returns once every queued word has been taken and answered and the pipeline
  // is certainly empty.
  task automatic wait_drained();
    while (pending_words.size() != 0 || words_taken != words_offered ||
           expected_responses.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Driver: all inputs change on the falling edge. A new word is presented
  // only once the previous one has been taken; until then the payload holds.
  always @(negedge clk) begin : drive_words
    port_word_t next_word;
    int         sender_pct;
    int         receiver_pct;
    case (idle_mode)
      IDLE_SENDER: begin
        sender_pct   = HEAVY_PCT;
        receiver_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_pct   = 0;
        receiver_pct = HEAVY_PCT;
      end
      IDLE_BOTH: begin
        sender_pct   = LIGHT_PCT;
        receiver_pct = LIGHT_PCT;
      end
      default: begin
        sender_pct   = 0;
        receiver_pct = 0;
      end
    endcase
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_pct);
      if (words_taken == words_offered) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_pct) begin
          next_word    = pending_words.pop_front();
          func        <= next_word.op;
          bus_address <= next_word.addr;
          write_data  <= next_word.wdata;
          key_code    <= next_word.key;
          in_valid    <= 1'b1;
          words_offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: everything is sampled on the rising edge. Accepted words are
  // predicted straight away, so the expected queue always mirrors the
  // order in which the block took them.
  always @(posedge clk) begin : check_results
    result_t want;
    cycle_count++;
    if (!rst) begin
      if (cfg_write_enable) begin
        model_base = cfg_write_data;
      end
      if (in_valid && !in_stall) begin
        expected_responses.push_back(
          predict_port_response(func_t'(func), bus_address, write_data, key_code));
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $error("Result word arrived with no word outstanding");
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          results_checked++;
          if (want.drive_bus) reads_answered++;
          if (want.key_accepted) keys_latched++;
          if (want.char_valid) chars_drained++;
          if (read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, read_data);
            mismatches++;
          end
          if (drive_bus !== want.drive_bus) begin
            $error("drive_bus: expected %0b, got %0b", want.drive_bus, drive_bus);
            mismatches++;
          end
          if (key_accepted !== want.key_accepted) begin
            $error("key_accepted: expected %0b, got %0b", want.key_accepted, key_accepted);
            mismatches++;
          end
          if (char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b, got %0b", want.char_valid, char_valid);
            mismatches++;
          end
          if (char_out !== want.char_out) begin
            $error("char_out: expected %02h, got %02h", want.char_out, char_out);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles with words still outstanding", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset base address. It walks both latches through
    // their flag transitions: reads of an empty port, a key dropped while the
    // flag is set, the clearing read, a display character drained once and
    // then polled again while empty, writes that the port must ignore, and
    // accesses just outside the window.
    idle_mode = IDLE_NONE;
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_CLEAR), 8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_PEEK),  8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_DISPLAY),   8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_UNUSED),    8'h00, 8'h00);
    queue_word(FUNC_DISP_POLL, 16'hFFFF,                   8'hFF, 8'hFF);
    queue_word(FUNC_KEY_OFFER, 16'h0000,                   8'h00, 8'hFF);
    queue_word(FUNC_KEY_OFFER, 16'hFFFF,                   8'hFF, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_PEEK),  8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_CLEAR), 8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_PEEK),  8'h00, 8'h00);
    queue_word(FUNC_KEY_OFFER, 16'h0000,                   8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_KEY_CLEAR), 8'h00, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_DISPLAY),   8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_DISPLAY),   8'h00, 8'h00);
    queue_word(FUNC_DISP_POLL, 16'h0000,                   8'h00, 8'h00);
    queue_word(FUNC_DISP_POLL, 16'h0000,                   8'h00, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_DISPLAY),   8'hFF, 8'h00);
    queue_word(FUNC_DISP_POLL, 16'h0000,                   8'h00, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_KEY_CLEAR), 8'h55, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_KEY_PEEK),  8'hAA, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_UNUSED),    8'h12, 8'h00);
    queue_word(FUNC_BUS_WRITE, reg_address(REG_DISPLAY) ^ 16'h0004, 8'h33, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_DISPLAY),   8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  16'hFFFF,                   8'h00, 8'h00);
    queue_word(FUNC_BUS_READ,  reg_address(REG_DISPLAY) - 16'h0004, 8'h00, 8'h00);

    // Random phases. Each one moves the window (both address extremes, a base
    // with its low bits set, the reset value and a few random ones) while the
    // port is idle, and cycles through the four idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      idle_mode = idle_mode_t'(p % 4);
      case (p)
        0: stim_base = 16'h0000;
        1: stim_base = 16'hFFFF;
        2: stim_base = 16'hD013;
        3: stim_base = BASE_RESET;
        6: stim_base = 16'h0003;
        default: stim_base = 16'($urandom);
      endcase
      cfg_write_data   <= stim_base;
      cfg_write_enable <= 1'b1;
      @(negedge clk);
      cfg_write_enable <= 1'b0;
      queue_random_words(PHASE_WORDS);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Checked %0d result words over %0d base address settings and four idling modes.",
             results_checked, PHASES + 1);
    $display("Bus reads answered %0d, keys latched %0d, display characters drained %0d.",
             reads_answered, keys_latched, chars_drained);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/kdpr_pkg.sv
hw/rtl/keyboard_display_port_registers.sv
hw/rtl/kdpr_checker.sv
sim/keyboard_display_port_registers_tb.sv
